FILE: design/q2e_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle converter.
`timescale 1ns / 1ps
`default_nettype none
package q2e_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_LEN         = 24;

    localparam int PW = 32;   // Q2.14 x Q2.14 product
    localparam int SW = 34;   // sine / cosine terms in units of 2^-28
    localparam int CW = 37;   // CORDIC x / y datapath
    localparam int ZW = 33;   // angle accumulator, 2^32 per turn
    localparam int QW = 58;   // square root datapath
    localparam int RW = 29;   // pitch sine below one in magnitude

    localparam int SQRT_CELLS = 29;   // result bits of sqrt(2^56 - s^2)
    localparam int SQRT_TOP   = 56;   // bit position of the first trial bit

    localparam int PITCH_MAX = 12868;
    localparam int ANGLE_MAX = 25736;

    localparam logic signed [SW-1:0] ONE_Q28   = SW'(268435456);
    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd2147483648);

    // pi in Q.29 split in two halves for the angle scaling
    localparam logic signed [15:0] PI_HI = 16'sd25735;
    localparam logic signed [16:0] PI_LO = 17'sd60753;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 hold;   // trivial angle, no rotation
    } q2e_rot_t;

    typedef struct packed {
        logic [QW-1:0] rad;
        logic [QW-1:0] root;
        logic          clamp_pos;
        logic          clamp_neg;
        logic [RW-1:0] sine;
    } q2e_sqrt_t;

    function automatic logic signed [ZW-1:0] atan_turn(input int idx);
        logic signed [ZW-1:0] v;
        begin
            unique case (idx)
                0:  v = ZW'(536870912);
                1:  v = ZW'(316933406);
                2:  v = ZW'(167458907);
                3:  v = ZW'(85004756);
                4:  v = ZW'(42667331);
                5:  v = ZW'(21354465);
                6:  v = ZW'(10679838);
                7:  v = ZW'(5340245);
                8:  v = ZW'(2670163);
                9:  v = ZW'(1335087);
                10: v = ZW'(667544);
                11: v = ZW'(333772);
                12: v = ZW'(166886);
                13: v = ZW'(83443);
                14: v = ZW'(41722);
                15: v = ZW'(20861);
                16: v = ZW'(10430);
                17: v = ZW'(5215);
                18: v = ZW'(2608);
                19: v = ZW'(1304);
                20: v = ZW'(652);
                21: v = ZW'(326);
                22: v = ZW'(163);
                23: v = ZW'(81);
                default: v = '0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

FILE: design/q2e_sqrt_cell.sv
// One restoring square root step: one result bit per cell.
`timescale 1ns / 1ps
`default_nettype none
module q2e_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  wire logic             clk,
    input  wire logic             en,
    input  wire q2e_pkg::q2e_sqrt_t d_in,
    output q2e_pkg::q2e_sqrt_t    d_out
);
    localparam logic [q2e_pkg::QW-1:0] TRIAL_BIT = q2e_pkg::QW'(1) << BIT_POS;

    q2e_pkg::q2e_sqrt_t d_reg;
    q2e_pkg::q2e_sqrt_t d_next;
    logic [q2e_pkg::QW-1:0] trial;

    always_comb
    begin
        trial  = d_in.root + TRIAL_BIT;
        d_next = d_in;
        if (d_in.rad >= trial)
        begin
            d_next.rad  = d_in.rad - trial;
            d_next.root = (d_in.root >> 1) + TRIAL_BIT;
        end
        else
        begin
            d_next.root = d_in.root >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

FILE: design/q2e_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its angle table entry.
`timescale 1ns / 1ps
`default_nettype none
module q2e_cordic_cell #(
    parameter int IDX = 0
) (
    input  wire logic              clk,
    input  wire logic              en,
    input  wire q2e_pkg::q2e_rot_t d_in,
    output q2e_pkg::q2e_rot_t      d_out
);
    localparam logic signed [q2e_pkg::ZW-1:0] TURN = q2e_pkg::atan_turn(IDX);

    q2e_pkg::q2e_rot_t d_reg;
    q2e_pkg::q2e_rot_t d_next;
    logic signed [q2e_pkg::CW-1:0] xs;
    logic signed [q2e_pkg::CW-1:0] ys;

    always_comb
    begin
        xs     = d_in.x >>> IDX;
        ys     = d_in.y >>> IDX;
        d_next = d_in;
        if (!d_in.hold)
        begin
            if (d_in.y >= 0)
            begin
                d_next.x = d_in.x + ys;
                d_next.y = d_in.y - xs;
                d_next.z = d_in.z + TURN;
            end
            else
            begin
                d_next.x = d_in.x - ys;
                d_next.y = d_in.y + xs;
                d_next.z = d_in.z - TURN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;
endmodule
`default_nettype wire

FILE: design/q2e_atan_lane.sv
// atan2 lane: quadrant fold, CORDIC cell row, scaling to Q3.13 and saturation.
`timescale 1ns / 1ps
`default_nettype none
module q2e_atan_lane #(
    parameter int STEPS = q2e_pkg::CORDIC_STEPS_DEF,
    parameter int LIM   = q2e_pkg::ANGLE_MAX
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [q2e_pkg::CW-1:0] y_in,
    input  wire logic signed [q2e_pkg::CW-1:0] x_in,
    output logic signed [15:0]                 angle
);
    localparam int ZW   = q2e_pkg::ZW;
    localparam int HW   = ZW + 16;
    localparam int LW   = ZW + 17;
    localparam int SUMW = ZW + 33;
    localparam int OW   = SUMW - 47;
    localparam logic signed [SUMW-1:0] ROUND = SUMW'(1) <<< 46;
    localparam logic signed [OW-1:0]   LIM_P = OW'(LIM);

    q2e_pkg::q2e_rot_t prep_next;
    q2e_pkg::q2e_rot_t chain [STEPS+1];

    logic signed [HW-1:0]   m_hi_reg;
    logic signed [LW-1:0]   m_lo_reg;
    logic signed [SUMW-1:0] sum;
    logic signed [OW-1:0]   r_reg;
    logic signed [15:0]     angle_reg;
    logic signed [15:0]     angle_next;

    // fold into the right half plane, flag the axis cases
    always_comb
    begin
        prep_next.x    = x_in;
        prep_next.y    = y_in;
        prep_next.z    = '0;
        prep_next.hold = 1'b0;
        if (y_in == 0)
        begin
            prep_next.hold = 1'b1;
            if (x_in < 0)
            begin
                prep_next.z = q2e_pkg::HALF_TURN;
            end
        end
        else if (x_in < 0)
        begin
            prep_next.x = -x_in;
            prep_next.y = -y_in;
            prep_next.z = (y_in >= 0) ? q2e_pkg::HALF_TURN : -q2e_pkg::HALF_TURN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chain[0] <= prep_next;
        end
    end

    for (genvar i = 0; i < STEPS; i++)
    begin : g_cell
        q2e_cordic_cell #(.IDX(i)) u_cell (
            .clk   (clk),
            .en    (en),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    // angle * pi(Q.29) as two half-width products, then round and shift
    assign sum = (SUMW'(m_hi_reg) <<< 16) + SUMW'(m_lo_reg) + ROUND;

    always_comb
    begin
        if (r_reg > LIM_P)
        begin
            angle_next = 16'(LIM_P);
        end
        else if (r_reg < -LIM_P)
        begin
            angle_next = 16'(-LIM_P);
        end
        else
        begin
            angle_next = r_reg[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_hi_reg  <= HW'(chain[STEPS].z) * HW'(q2e_pkg::PI_HI);
            m_lo_reg  <= LW'(chain[STEPS].z) * LW'(q2e_pkg::PI_LO);
            r_reg     <= sum[SUMW-1:47];
            angle_reg <= angle_next;
        end
    end

    assign angle = angle_reg;
endmodule
`default_nettype wire

FILE: design/quaternion_to_euler.sv
// Top level: quaternion (Q2.14) to pitch (Q2.13) / yaw / roll (Q3.13) pipeline.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-------------------------------------------
//  in       | in_valid, in_stall  | quat_w, quat_x, quat_y, quat_z
//  out      | out_valid, out_stall| pitch_angle, yaw_angle, roll_angle,
//           |                     | gimbal_clamped
//
// One request per clock while the pipe is not held. The pitch path passes the
// product and sum stages, the 29-cell square root row for the pitch cosine,
// the CORDIC lane, and the output register.
// Reset clears only the valid bits; payload registers are not reset.
// The whole pipe, bubbles included, holds while the output register is full
// and stalled; in_stall is that same condition, and everything moves otherwise.
`timescale 1ns / 1ps
`default_nettype none
module quaternion_to_euler #(
    parameter int CORDIC_STEPS = q2e_pkg::CORDIC_STEPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] quat_w,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [14:0]      pitch_angle,
    output logic signed [15:0]      yaw_angle,
    output logic signed [15:0]      roll_angle,
    output logic                    gimbal_clamped
);
    localparam int PW       = q2e_pkg::PW;
    localparam int SW       = q2e_pkg::SW;
    localparam int CW       = q2e_pkg::CW;
    localparam int QW       = q2e_pkg::QW;
    localparam int RW       = q2e_pkg::RW;
    localparam int NCELL    = q2e_pkg::SQRT_CELLS;
    localparam int LANE_LAT = CORDIC_STEPS + 4;
    localparam int YR_DLY   = NCELL + 2;           // S3, S4 and the sqrt row
    localparam int NV       = 4 + NCELL + LANE_LAT;
    localparam logic [QW-1:0] ONE_SQ = QW'(1) << 56;
    localparam logic signed [14:0] PMAX = 15'(q2e_pkg::PITCH_MAX);

    logic adv;
    logic [NV-1:0] vld_reg;
    logic          out_valid_reg;

    // S1 products
    logic signed [PW-1:0] p_wx_reg, p_yz_reg, p_wy_reg, p_zx_reg, p_xx_reg;
    logic signed [PW-1:0] p_yy_reg, p_wz_reg, p_xy_reg, p_zz_reg;
    // S2 sine / cosine terms
    logic signed [SW-1:0] sinp_reg, siny_reg, cosy_reg, sinr_reg, cosr_reg;
    // S3 pitch magnitude squared
    logic [55:0]          mag_sq_reg;
    logic [27:0]          mag;
    logic                 s3_pos_reg, s3_neg_reg;
    logic [RW-1:0]        s3_sine_reg;
    // S4 and sqrt row
    q2e_pkg::q2e_sqrt_t   sq [NCELL+1];

    logic signed [15:0] pitch_lane, yaw_lane, roll_lane;
    logic [31:0] yr_reg [YR_DLY];
    logic [1:0]  cl_reg [LANE_LAT];

    logic signed [14:0] pitch_reg, pitch_next;
    logic signed [15:0] yaw_reg, roll_reg;
    logic               clamp_reg;

    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg       <= {vld_reg[NV-2:0], in_valid};
            out_valid_reg <= vld_reg[NV-1];
        end
    end

    assign mag = sinp_reg[SW-1] ? 28'(-sinp_reg) : sinp_reg[27:0];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_wx_reg <= PW'(quat_w) * PW'(quat_x);
            p_yz_reg <= PW'(quat_y) * PW'(quat_z);
            p_wy_reg <= PW'(quat_w) * PW'(quat_y);
            p_zx_reg <= PW'(quat_z) * PW'(quat_x);
            p_xx_reg <= PW'(quat_x) * PW'(quat_x);
            p_yy_reg <= PW'(quat_y) * PW'(quat_y);
            p_wz_reg <= PW'(quat_w) * PW'(quat_z);
            p_xy_reg <= PW'(quat_x) * PW'(quat_y);
            p_zz_reg <= PW'(quat_z) * PW'(quat_z);

            sinp_reg <= (SW'(p_wx_reg) - SW'(p_yz_reg)) <<< 1;
            siny_reg <= (SW'(p_wy_reg) + SW'(p_zx_reg)) <<< 1;
            cosy_reg <= q2e_pkg::ONE_Q28 - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1);
            sinr_reg <= (SW'(p_wz_reg) + SW'(p_xy_reg)) <<< 1;
            cosr_reg <= q2e_pkg::ONE_Q28 - ((SW'(p_zz_reg) + SW'(p_xx_reg)) <<< 1);

            // clamped items carry garbage down the sqrt row; overridden at the end
            mag_sq_reg  <= 56'(mag) * 56'(mag);
            s3_pos_reg  <= (sinp_reg >= q2e_pkg::ONE_Q28);
            s3_neg_reg  <= (sinp_reg <= -q2e_pkg::ONE_Q28);
            s3_sine_reg <= sinp_reg[RW-1:0];

            sq[0].rad       <= ONE_SQ - QW'(mag_sq_reg);
            sq[0].root      <= '0;
            sq[0].clamp_pos <= s3_pos_reg;
            sq[0].clamp_neg <= s3_neg_reg;
            sq[0].sine      <= s3_sine_reg;
        end
    end

    for (genvar k = 0; k < NCELL; k++)
    begin : g_sqrt
        q2e_sqrt_cell #(.BIT_POS(q2e_pkg::SQRT_TOP - 2 * k)) u_sqrt (
            .clk   (clk),
            .en    (adv),
            .d_in  (sq[k]),
            .d_out (sq[k+1])
        );
    end

    q2e_atan_lane #(.STEPS(CORDIC_STEPS), .LIM(q2e_pkg::PITCH_MAX)) u_pitch (
        .clk   (clk),
        .en    (adv),
        .y_in  (CW'($signed(sq[NCELL].sine))),
        .x_in  (CW'($signed({1'b0, sq[NCELL].root[NCELL-1:0]}))),
        .angle (pitch_lane)
    );

    q2e_atan_lane #(.STEPS(CORDIC_STEPS), .LIM(q2e_pkg::ANGLE_MAX)) u_yaw (
        .clk   (clk),
        .en    (adv),
        .y_in  (CW'(siny_reg)),
        .x_in  (CW'(cosy_reg)),
        .angle (yaw_lane)
    );

    q2e_atan_lane #(.STEPS(CORDIC_STEPS), .LIM(q2e_pkg::ANGLE_MAX)) u_roll (
        .clk   (clk),
        .en    (adv),
        .y_in  (CW'(sinr_reg)),
        .x_in  (CW'(cosr_reg)),
        .angle (roll_lane)
    );

    // align yaw/roll with the later-starting pitch lane, and the clamp flags
    // with the pitch lane
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            yr_reg[0] <= {yaw_lane, roll_lane};
            for (int i = 1; i < YR_DLY; i++)
            begin
                yr_reg[i] <= yr_reg[i-1];
            end
            cl_reg[0] <= {sq[NCELL].clamp_pos, sq[NCELL].clamp_neg};
            for (int j = 1; j < LANE_LAT; j++)
            begin
                cl_reg[j] <= cl_reg[j-1];
            end
        end
    end

    always_comb
    begin
        priority if (cl_reg[LANE_LAT-1][1])
        begin
            pitch_next = PMAX;
        end
        else if (cl_reg[LANE_LAT-1][0])
        begin
            pitch_next = -PMAX;
        end
        else
        begin
            pitch_next = pitch_lane[14:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pitch_reg <= pitch_next;
            yaw_reg   <= yr_reg[YR_DLY-1][31:16];
            roll_reg  <= yr_reg[YR_DLY-1][15:0];
            clamp_reg <= |cl_reg[LANE_LAT-1];
        end
    end

    assign out_valid      = out_valid_reg;
    assign pitch_angle    = pitch_reg;
    assign yaw_angle      = yaw_reg;
    assign roll_angle     = roll_reg;
    assign gimbal_clamped = clamp_reg;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled while output can move");

    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && gimbal_clamped) |-> (pitch_angle == PMAX || pitch_angle == -PMAX))
        else $error("clamp flag without limit pitch");

    a_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pitch_angle <= PMAX && pitch_angle >= -PMAX))
        else $error("pitch out of range");

    a_yaw_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (yaw_angle <= 16'sd25736 && yaw_angle >= -16'sd25736))
        else $error("yaw out of range");
`endif
endmodule
`default_nettype wire
